### design/svf_pkg.sv
// Shared types and constants of the double-sampled state-variable filter.
package svf_pkg;

	localparam int COEF_BITS      = 24;
	localparam int COEF_FRAC      = 22;
	localparam int STATE_INT_BITS = 8;
	localparam int MUL_CHUNK      = 24;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [2:0] MODE_BYPASS = 3'd0;
	localparam logic [2:0] MODE_LOW    = 3'd1;
	localparam logic [2:0] MODE_BAND   = 3'd2;
	localparam logic [2:0] MODE_HIGH   = 3'd3;
	localparam logic [2:0] MODE_NOTCH  = 3'd4;
	localparam logic [2:0] MODE_PEAK   = 3'd5;

	localparam logic [CFG_INDEX_BITS-1:0] REG_MODE  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FREQ  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DAMP  = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DRIVE = 2'd3;

	localparam logic [COEF_BITS-1:0] FREQ_RESET  = 24'h100000;
	localparam logic [COEF_BITS-1:0] DRIVE_RESET = 24'h200000;

	typedef struct packed {
		logic [2:0]           mode;
		logic [COEF_BITS-1:0] freq;
		logic [COEF_BITS-1:0] damp;
		logic [COEF_BITS-1:0] drive;
	} svf_cfg_t;

	// wide: chunk the whole second operand and drop the state fraction bits,
	// otherwise the second operand is a coefficient and one chunk suffices
	typedef struct packed {
		logic start;
		logic wide;
	} svf_mul_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NOTCH,
		ST_LOW,
		ST_HIGH,
		ST_SQ,
		ST_CUBE,
		ST_DRV,
		ST_FH,
		ST_PICK,
		ST_AVG,
		ST_DONE
	} svf_state_t;

endpackage

### design/state_variable_filter_double_sampled.sv
// Double-sampled state-variable filter with cubic band-path drive.
//
// Input stream s_axis_*: one signed audio sample per request in tdata.
// Output stream m_axis_*: one filtered sample per input request, in order.
// Config channel cfg_*: index 0 response mode (write clears both integrators),
// 1 tuning coefficient, 2 damping coefficient, 3 drive weight; cfg_ready is
// always high. Writes are made only while the filter is idle: the user keeps
// to this, as the block itself does not enforce it. Each sample outside bypass
// mode runs two filter passes through one shared multiplier; a coefficient
// product uses one chunk of its second operand and a square or cube product
// chunks its whole second operand. Bypass mode goes straight to the result.
// The next sample is accepted in the cycle after the output register takes a
// result, so the filter takes a new sample only once the last one's result
// has left the sequencer.
// s_axis_tready is high only while the sequencer is idle. A result waits in the
// output register, so the next sample is accepted while m_axis_tready is low;
// that sample's result then holds in the sequencer until the register frees.
// Reset clears the integrators, loads the register defaults (bypass mode)
// and empties the output register.
module state_variable_filter_double_sampled #(
	parameter int  SAMPLE_BITS = 24,
	parameter int  STATE_BITS  = 32,
	localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [TDATA_BITS-1:0]               s_axis_tdata,   // [SAMPLE_BITS-1:0] sample_in
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [TDATA_BITS-1:0]               m_axis_tdata,   // [SAMPLE_BITS-1:0] sample_out
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [svf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [svf_pkg::COEF_BITS-1:0]       cfg_data
);
	import svf_pkg::*;

	svf_cfg_t                    cfg_q;
	logic                        cfg_we;
	logic                        clr;
	logic                        start;
	logic                        idle;
	logic                        res_valid;
	logic [SAMPLE_BITS-1:0]      res_data;
	logic                        load;
	logic                        m_valid_q;
	logic [SAMPLE_BITS-1:0]      m_data_q;
	svf_mul_ctl_t                mul_ctl;
	logic signed [STATE_BITS-1:0] mul_a;
	logic signed [STATE_BITS:0]   mul_b;
	logic                        mul_done;
	logic signed [STATE_BITS-1:0] mul_res;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign clr       = cfg_we && (cfg_index == REG_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{mode: MODE_BYPASS, freq: FREQ_RESET, damp: '0, drive: DRIVE_RESET};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:  cfg_q.mode  <= cfg_data[2:0];
				REG_FREQ:  cfg_q.freq  <= cfg_data;
				REG_DAMP:  cfg_q.damp  <= cfg_data;
				REG_DRIVE: cfg_q.drive <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = idle;
	assign start         = s_axis_tvalid && idle;

	svf_seq #(.SB(SAMPLE_BITS), .S(STATE_BITS)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
		.cfg       (cfg_q),
		.clr       (clr),
		.idle      (idle),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_take  (load),
		.mul_ctl   (mul_ctl),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.mul_done  (mul_done),
		.mul_res   (mul_res)
	);

	svf_mul #(.S(STATE_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.result (mul_res)
	);

	// advance the output register when it is empty or being drained
	assign load = res_valid && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_data_q <= res_data;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = TDATA_BITS'(m_data_q);

endmodule

### design/svf_rescale.sv
// Fixed-point format change: shift (rounding half away from zero on a right shift), then saturate.
module svf_rescale #(
	parameter int IW    = 24,
	parameter int OW    = 32,
	parameter int SHIFT = 1
) (
	input  logic signed [IW-1:0] din,
	output logic signed [OW-1:0] dout
);

	generate
		if (SHIFT >= 0) begin : g_left
			localparam int EW = ((IW + SHIFT > OW) ? IW + SHIFT : OW) + 1;
			localparam logic signed [EW-1:0] MAXV = {{(EW-OW+1){1'b0}}, {(OW-1){1'b1}}};
			localparam logic signed [EW-1:0] MINV = ~MAXV;
			logic signed [EW-1:0] ext;

			assign ext = EW'(din) <<< SHIFT;
			always_comb begin
				if (ext > MAXV) begin
					dout = MAXV[OW-1:0];
				end else if (ext < MINV) begin
					dout = MINV[OW-1:0];
				end else begin
					dout = ext[OW-1:0];
				end
			end
		end else begin : g_right
			localparam int R  = -SHIFT;
			localparam int CW = (IW + 2 > OW + 1) ? IW + 2 : OW + 1;
			localparam logic [CW-1:0] HALF = CW'(1) << (R - 1);
			localparam logic [CW-1:0] LIMP = {{(CW-OW+1){1'b0}}, {(OW-1){1'b1}}};
			localparam logic [CW-1:0] LIMN = LIMP + CW'(1);
			logic signed [CW-1:0] wide;
			logic                 neg;
			logic [CW-1:0]        mag;
			logic [CW-1:0]        rnd;
			logic [CW-1:0]        lim;
			logic [OW-1:0]        mo;

			assign wide = CW'(din);
			assign neg  = din[IW-1];
			assign mag  = neg ? CW'(-wide) : CW'(wide);
			assign rnd  = (mag + HALF) >> R;
			assign lim  = neg ? LIMN : LIMP;
			assign mo   = (rnd > lim) ? lim[OW-1:0] : rnd[OW-1:0];
			assign dout = neg ? $signed(OW'(~mo + 1'b1)) : $signed(mo);
		end
	endgenerate

endmodule

### design/svf_mul.sv
// Shared multiplier: chunked magnitude product, rounding half away from zero, saturation.
module svf_mul #(
	parameter int S = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  svf_pkg::svf_mul_ctl_t ctl,
	input  logic signed [S-1:0]   op_a,
	input  logic signed [S:0]     op_b,
	output logic                  done,
	output logic signed [S-1:0]   result
);
	import svf_pkg::*;

	localparam int CH   = MUL_CHUNK;
	localparam int NCH  = (S + CH - 1) / CH;
	localparam int BPW  = NCH * CH;
	localparam int PW   = S + BPW;
	localparam int CNTW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int SH_S = S - STATE_INT_BITS;
	localparam int SH_C = COEF_FRAC;
	localparam logic [PW:0] HALF_S = (PW+1)'(1) << (SH_S - 1);
	localparam logic [PW:0] HALF_C = (PW+1)'(1) << (SH_C - 1);
	localparam logic [PW:0] LIMP   = {{(PW-S+2){1'b0}}, {(S-1){1'b1}}};
	localparam logic [PW:0] LIMN   = LIMP + (PW+1)'(1);

	logic [S-1:0]    amag;
	logic [S:0]      bfull;
	logic [BPW-1:0]  bpad;
	logic [CH-1:0]   first_chunk;
	logic [S-1:0]    mul_a;
	logic [CH-1:0]   mul_b;
	logic [S+CH-1:0] prod;
	logic [PW-1:0]   acc_base;
	logic [PW-1:0]   acc_n;
	logic [PW:0]     r_s;
	logic [PW:0]     r_c;
	logic [PW:0]     rmag;
	logic [PW:0]     lim;
	logic [S-1:0]    mo;
	logic signed [S-1:0] rounded;

	logic            busy_q;
	logic            done_q;
	logic [S-1:0]    amag_q;
	logic [BPW-1:0]  bmag_q;
	logic [CNTW-1:0] cnt_q;
	logic            neg_q;
	logic            wide_q;
	logic [PW-1:0]   acc_q;
	logic signed [S-1:0] res_q;

	assign amag        = op_a[S-1] ? S'(-op_a) : S'(op_a);
	assign bfull       = op_b[S] ? (S+1)'(-op_b) : (S+1)'(op_b);
	assign bpad        = BPW'(bfull[S-1:0]);
	assign first_chunk = ctl.wide ? bpad[BPW-1 -: CH] : bpad[CH-1:0];

	// one multiplier: the first chunk on a request, the next chunk while busy
	assign mul_a    = ctl.start ? amag : amag_q;
	assign mul_b    = ctl.start ? first_chunk : bmag_q[BPW-1 -: CH];
	assign prod     = mul_a * mul_b;
	assign acc_base = ctl.start ? '0 : (acc_q << CH);
	assign acc_n    = acc_base + PW'(prod);

	assign r_s     = ({1'b0, acc_q} + HALF_S) >> SH_S;
	assign r_c     = ({1'b0, acc_q} + HALF_C) >> SH_C;
	assign rmag    = wide_q ? r_s : r_c;
	assign lim     = neg_q ? LIMN : LIMP;
	assign mo      = (rmag > lim) ? lim[S-1:0] : rmag[S-1:0];
	assign rounded = neg_q ? $signed(S'(~mo + 1'b1)) : $signed(mo);

	assign done   = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			amag_q <= amag;
			bmag_q <= bpad << CH;
			cnt_q  <= ctl.wide ? CNTW'(NCH - 1) : '0;
			neg_q  <= op_a[S-1] ^ op_b[S];
			wide_q <= ctl.wide;
			acc_q  <= acc_n;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				acc_q  <= acc_n;
				bmag_q <= bmag_q << CH;
				cnt_q  <= cnt_q - CNTW'(1);
			end else begin
				res_q <= rounded;
			end
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q)
		else $error("multiplier request while busy");
	a_last_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == '0 && !ctl.start) |=> (done_q && !busy_q))
		else $error("product not delivered after last chunk");
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(ctl.start))
		else $error("multiplier busy without request");

endmodule

### design/svf_seq.sv
// Sequencer and datapath: two filter passes per sample outside bypass mode over the shared multiplier.
module svf_seq #(
	parameter int SB = 24,
	parameter int S  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [SB-1:0]  sample,
	input  svf_pkg::svf_cfg_t     cfg,
	input  logic                  clr,
	output logic                  idle,
	output logic                  res_valid,
	output logic [SB-1:0]         res_data,
	input  logic                  res_take,
	output svf_pkg::svf_mul_ctl_t mul_ctl,
	output logic signed [S-1:0]   mul_a,
	output logic signed [S:0]     mul_b,
	input  logic                  mul_done,
	input  logic signed [S-1:0]   mul_res
);
	import svf_pkg::*;

	svf_state_t state_q;
	svf_state_t state_n;
	logic       issued_q;
	logic       pass_q;
	logic       mult_st;

	logic signed [S-1:0]  low_q;
	logic signed [S-1:0]  band_q;
	logic signed [S-1:0]  x_q;
	logic signed [S-1:0]  notch_q;
	logic signed [S-1:0]  high_q;
	logic signed [S-1:0]  tmp_q;
	logic signed [S-1:0]  drv_q;
	logic signed [S:0]    sum_q;
	logic signed [S-1:0]  avg_q;
	logic [SB-1:0]        raw_q;

	logic signed [S-1:0]  x_r;
	logic signed [S-1:0]  avg_r;
	logic signed [SB-1:0] y_r;
	logic signed [S-1:0]  peak;
	logic signed [S-1:0]  sel;

	function automatic logic signed [S-1:0] sat_st(input logic signed [S+1:0] v);
		logic signed [S+1:0] maxv;
		logic signed [S+1:0] minv;
		maxv = {3'b000, {(S-1){1'b1}}};
		minv = ~maxv;
		if (v > maxv) begin
			return maxv[S-1:0];
		end else if (v < minv) begin
			return minv[S-1:0];
		end
		return v[S-1:0];
	endfunction

	svf_rescale #(.IW(SB), .OW(S), .SHIFT(S - SB - 7)) u_in_scale (
		.din  (sample),
		.dout (x_r)
	);

	svf_rescale #(.IW(S + 1), .OW(S), .SHIFT(-1)) u_avg (
		.din  (sum_q),
		.dout (avg_r)
	);

	svf_rescale #(.IW(S), .OW(SB), .SHIFT(SB - S + 7)) u_out_scale (
		.din  (avg_q),
		.dout (y_r)
	);

	assign peak = sat_st((S+2)'(low_q) - (S+2)'(high_q));

	always_comb begin
		case (cfg.mode)
			MODE_LOW:   sel = low_q;
			MODE_BAND:  sel = band_q;
			MODE_HIGH:  sel = high_q;
			MODE_NOTCH: sel = notch_q;
			MODE_PEAK:  sel = peak;
			default:    sel = '0;
		endcase
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_n = (cfg.mode == MODE_BYPASS) ? ST_DONE : ST_NOTCH;
				end
			end
			ST_NOTCH: if (mul_done) state_n = ST_LOW;
			ST_LOW:   if (mul_done) state_n = ST_HIGH;
			ST_HIGH:  state_n = ST_SQ;
			ST_SQ:    if (mul_done) state_n = ST_CUBE;
			ST_CUBE:  if (mul_done) state_n = ST_DRV;
			ST_DRV:   if (mul_done) state_n = ST_FH;
			ST_FH:    if (mul_done) state_n = ST_PICK;
			ST_PICK:  state_n = pass_q ? ST_AVG : ST_NOTCH;
			ST_AVG:   state_n = ST_DONE;
			ST_DONE:  if (res_take) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	// outputs and multiplier operands
	always_comb begin
		mult_st   = 1'b0;
		mul_ctl   = '{start: 1'b0, wide: 1'b0};
		mul_a     = band_q;
		mul_b     = (S+1)'(band_q);
		idle      = (state_q == ST_IDLE);
		res_valid = (state_q == ST_DONE);
		res_data  = (cfg.mode inside {[MODE_LOW:MODE_PEAK]}) ? y_r : raw_q;
		case (state_q)
			ST_NOTCH: begin
				mult_st = 1'b1;
				mul_b   = (S+1)'(cfg.damp);
			end
			ST_LOW: begin
				mult_st = 1'b1;
				mul_b   = (S+1)'(cfg.freq);
			end
			ST_SQ: begin
				mult_st      = 1'b1;
				mul_ctl.wide = 1'b1;
			end
			ST_CUBE: begin
				mult_st      = 1'b1;
				mul_ctl.wide = 1'b1;
				mul_a        = tmp_q;
			end
			ST_DRV: begin
				mult_st = 1'b1;
				mul_a   = tmp_q;
				mul_b   = (S+1)'(cfg.drive);
			end
			ST_FH: begin
				mult_st = 1'b1;
				mul_a   = high_q;
				mul_b   = (S+1)'(cfg.freq);
			end
			default: ;
		endcase
		mul_ctl.start = mult_st && !issued_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
			pass_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			if (mul_ctl.start) begin
				issued_q <= 1'b1;
			end else if (mul_done) begin
				issued_q <= 1'b0;
			end
			if (state_q == ST_IDLE) begin
				pass_q <= 1'b0;
			end else if (state_q == ST_PICK) begin
				pass_q <= 1'b1;
			end
		end
	end

	// integrators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			band_q <= '0;
		end else if (clr) begin
			low_q  <= '0;
			band_q <= '0;
		end else begin
			if (state_q == ST_LOW && mul_done) begin
				low_q <= sat_st((S+2)'(low_q) + (S+2)'(mul_res));
			end
			if (state_q == ST_FH && mul_done) begin
				band_q <= sat_st((S+2)'(mul_res) + (S+2)'(band_q) - (S+2)'(drv_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					raw_q <= sample;
					x_q   <= x_r;
				end
			end
			ST_NOTCH: if (mul_done) notch_q <= sat_st((S+2)'(x_q) - (S+2)'(mul_res));
			ST_HIGH:  high_q <= sat_st((S+2)'(notch_q) - (S+2)'(low_q));
			ST_SQ:    if (mul_done) tmp_q <= mul_res;
			ST_CUBE:  if (mul_done) tmp_q <= mul_res;
			ST_DRV:   if (mul_done) drv_q <= mul_res;
			ST_PICK: begin
				// first pass loads, second pass adds
				if (pass_q) begin
					sum_q <= sum_q + (S+1)'(sel);
				end else begin
					sum_q <= (S+1)'(sel);
				end
			end
			ST_AVG:   avg_q <= avg_r;
			default: ;
		endcase
	end

	a_bypass_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == ST_IDLE && cfg.mode == MODE_BYPASS) |=> (state_q == ST_DONE))
		else $error("bypass sample did not go straight to result");
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!clr && state_q != ST_LOW && state_q != ST_FH) |=> ($stable(low_q) && $stable(band_q)))
		else $error("integrator changed outside its update step");
	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> issued_q)
		else $error("product returned without request");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_take && state_q == ST_DONE) |=> (state_q == ST_IDLE))
		else $error("sequencer did not release after result taken");

endmodule

### bench/state_variable_filter_double_sampled_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the double-sampled state-variable filter: random streams checked against a bit-true predictor.
module state_variable_filter_double_sampled_test;
	import svf_pkg::*;

	localparam int SAMPLE_BITS = 24;
	localparam int STATE_BITS  = 32;
	localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int STATE_FRAC  = STATE_BITS - STATE_INT_BITS;
	localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;

	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX  = 24'h7FFFFF;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN  = 24'h800000;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONE  = 24'h000001;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_NEG1 = 24'hFFFFFF;
	localparam logic [COEF_BITS-1:0]   COEF_MAX    = 24'hFFFFFF;

	localparam int SETTLE_CYCLES  = 64;
	localparam int LONG_STALL     = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_SAMPLES  = 90;

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [TDATA_BITS-1:0]     s_axis_tdata  = '0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [TDATA_BITS-1:0]     m_axis_tdata;
	logic                      cfg_valid     = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
	logic [COEF_BITS-1:0]      cfg_data      = '0;

	state_variable_filter_double_sampled #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.STATE_BITS (STATE_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// predictor copy of the filter registers and integrators
	logic [2:0]                   flt_mode  = MODE_BYPASS;
	logic [COEF_BITS-1:0]         flt_freq  = FREQ_RESET;
	logic [COEF_BITS-1:0]         flt_damp  = '0;
	logic [COEF_BITS-1:0]         flt_drive = DRIVE_RESET;
	logic signed [STATE_BITS-1:0] low_acc   = '0;
	logic signed [STATE_BITS-1:0] band_acc  = '0;

	logic [SAMPLE_BITS-1:0] pending_samples[$];
	logic [SAMPLE_BITS-1:0] expected_outputs[$];

	logic sample_fired = 1'b0;
	logic result_fired = 1'b0;
	bit   src_idle     = 1'b0;
	bit   sink_idle    = 1'b0;
	int   src_wait     = 0;
	int   sink_wait    = 0;
	int   stall_left   = 0;
	int   long_stall_request = 0;

	int mismatches       = 0;
	int samples_accepted = 0;
	int results_checked  = 0;
	int settings_used    = 0;
	int reg_writes       = 0;
	int quiet_cycles     = 0;
	int mode_hits[8];

	// a*b / 2^sh, rounded half away from zero, saturated to a signed range of bits
	function automatic longint scaled_product(input longint a, input longint b, input int sh,
			input int bits);
		logic [127:0] ua, ub, mag, lim;
		logic         neg;
		neg = (a < 0) != (b < 0);
		ua  = (a < 0) ? 128'(-a) : 128'(a);
		ub  = (b < 0) ? 128'(-b) : 128'(b);
		mag = ua * ub;
		if (sh > 0)
			mag = (mag + (128'd1 << (sh - 1))) >> sh;
		lim = (128'd1 << (bits - 1)) - (neg ? 128'd0 : 128'd1);
		if (mag > lim)
			mag = lim;
		return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
	endfunction

	function automatic longint clamp_state(input longint v);
		longint top;
		top = (longint'(1) <<< (STATE_BITS - 1)) - 1;
		if (v > top)
			return top;
		if (v < -top - 1)
			return -top - 1;
		return v;
	endfunction

	// one pass through both integrators; returns the tap that the mode selects
	function automatic longint filter_pass(input longint x, input logic [2:0] mode);
		longint band, notch, low, high, sq, cube, drv, fh;
		band  = band_acc;
		notch = clamp_state(x - scaled_product(flt_damp, band, COEF_FRAC, STATE_BITS));
		low   = clamp_state(low_acc + scaled_product(flt_freq, band, COEF_FRAC, STATE_BITS));
		high  = clamp_state(notch - low);
		sq    = scaled_product(band, band, STATE_FRAC, STATE_BITS);
		cube  = scaled_product(sq, band, STATE_FRAC, STATE_BITS);
		drv   = scaled_product(flt_drive, cube, COEF_FRAC, STATE_BITS);
		fh    = scaled_product(flt_freq, high, COEF_FRAC, STATE_BITS);
		band  = clamp_state(fh + band - drv);
		low_acc  = low[STATE_BITS-1:0];
		band_acc = band[STATE_BITS-1:0];
		case (mode)
			MODE_LOW:   return low;
			MODE_BAND:  return band;
			MODE_HIGH:  return high;
			MODE_NOTCH: return notch;
			MODE_PEAK:  return clamp_state(low - high);
			default:    return 0;
		endcase
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] filtered_sample(input logic [SAMPLE_BITS-1:0] raw);
		longint x, first_pass, second_pass, avg, y;
		if (flt_mode == MODE_BYPASS)
			return raw;
		x = scaled_product(longint'($signed(raw)), longint'(1) <<< (STATE_FRAC - SAMPLE_FRAC), 0,
			STATE_BITS);
		first_pass  = filter_pass(x, flt_mode);
		second_pass = filter_pass(x, flt_mode);
		// spare modes update the state but pass the sample through
		if (flt_mode > MODE_PEAK)
			return raw;
		avg = scaled_product(first_pass + second_pass, 1, 1, STATE_BITS);
		y   = scaled_product(avg, 1, STATE_FRAC - SAMPLE_FRAC, SAMPLE_BITS);
		return y[SAMPLE_BITS-1:0];
	endfunction

	// predict on accepted requests, check results, watch for a hang
	always @(posedge clk) begin : monitor
		logic [SAMPLE_BITS-1:0] want;
		sample_fired <= s_axis_tvalid && s_axis_tready;
		result_fired <= m_axis_tvalid && m_axis_tready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE: begin
						flt_mode = cfg_data[2:0];
						low_acc  = '0;
						band_acc = '0;
					end
					REG_FREQ:  flt_freq  = cfg_data;
					REG_DAMP:  flt_damp  = cfg_data;
					REG_DRIVE: flt_drive = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				mode_hits[flt_mode]++;
				samples_accepted++;
				expected_outputs.push_back(filtered_sample(s_axis_tdata[SAMPLE_BITS-1:0]));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				results_checked++;
				if (expected_outputs.size() == 0) begin
					mismatches++;
					$display("%0t: sample_out %h arrived with none expected", $time, m_axis_tdata);
				end else begin
					want = expected_outputs.pop_front();
					if (m_axis_tdata !== TDATA_BITS'(want)) begin
						mismatches++;
						$display("%0t: sample_out mismatch, expected %h, got %h", $time, want,
							m_axis_tdata);
					end
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no request moved for %0d cycles, %0d results outstanding", $time,
					quiet_cycles, expected_outputs.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	always @(negedge clk) begin : sender
		if (arst_n && (!s_axis_tvalid || sample_fired)) begin
			if (src_wait > 0) begin
				src_wait--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				s_axis_tdata  <= pending_samples.pop_front();
				s_axis_tvalid <= 1'b1;
				src_wait = src_idle ? $urandom_range(0, 8) : 0;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (long_stall_request > 0) begin
				stall_left = long_stall_request;
				long_stall_request = 0;
			end
			if (result_fired)
				sink_wait = sink_idle ? $urandom_range(0, 8) : 0;
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (sink_wait > 0) begin
				sink_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [COEF_BITS-1:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
	endtask

	// hold until every request has gone through and the filter is idle again
	task automatic drain_filter();
		while (pending_samples.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return SAMPLE_BITS'($urandom);
		if (pick < 85)
			return SAMPLE_BITS'(int'($urandom_range(0, 131072)) - 65536);
		case ($urandom_range(0, 4))
			0:       return SAMPLE_MAX;
			1:       return SAMPLE_MIN;
			2:       return SAMPLE_ONE;
			3:       return SAMPLE_NEG1;
			default: return '0;
		endcase
	endfunction

	// mostly values that keep the filter stable, with the extremes mixed in
	function automatic logic [COEF_BITS-1:0] random_coef(input int lo, input int hi);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return COEF_MAX;
			2, 3:    return COEF_BITS'($urandom);
			default: return COEF_BITS'($urandom_range(lo, hi));
		endcase
	endfunction

	function automatic logic [2:0] random_mode();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 14)
			return 3'($urandom_range(MODE_LOW, MODE_PEAK));
		if (pick < 17)
			return MODE_BYPASS;
		return 3'($urandom_range(MODE_SPARE_A, MODE_SPARE_B));
	endfunction

	// write a random subset of the registers, in index order from a random first register
	task automatic configure_random();
		int                        first, k;
		bit                        any;
		logic [CFG_INDEX_BITS-1:0] idx;
		first = $urandom_range(0, 3);
		any   = 1'b0;
		for (k = 0; k < 4; k++) begin
			idx = CFG_INDEX_BITS'((first + k) % 4);
			if ($urandom_range(0, 9) < 6 || (k == 3 && !any)) begin
				any = 1'b1;
				case (idx)
					REG_MODE:  write_register(idx, {($urandom_range(0, 1) ? 21'($urandom) : 21'd0),
						random_mode()});
					REG_FREQ:  write_register(idx, random_coef(24'h010000, 24'h200000));
					REG_DAMP:  write_register(idx, random_coef(24'h080000, 24'h600000));
					REG_DRIVE: write_register(idx, random_coef(0, 24'h400000));
					default: ;
				endcase
			end
		end
		settings_used++;
	endtask

	initial begin : stimulus
		int m, p, n;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle  = 1'b1;
		sink_idle = 1'b1;
		// reset state is bypass
		pending_samples.push_back(SAMPLE_MAX);
		pending_samples.push_back(SAMPLE_MIN);
		pending_samples.push_back(SAMPLE_ONE);
		drain_filter();

		// fastest tuning, no damping or drive: drive the integrators into saturation
		write_register(REG_FREQ, COEF_MAX);
		write_register(REG_DAMP, '0);
		write_register(REG_DRIVE, '0);
		write_register(REG_MODE, COEF_BITS'(MODE_LOW));
		settings_used++;
		repeat (3) pending_samples.push_back(SAMPLE_MAX);
		pending_samples.push_back(SAMPLE_MIN);
		drain_filter();

		// rewriting the same mode still clears the integrators
		write_register(REG_MODE, COEF_BITS'(MODE_LOW));
		pending_samples.push_back(SAMPLE_MAX);
		drain_filter();

		// upper data bits of a mode write are dropped
		write_register(REG_DAMP, COEF_MAX);
		write_register(REG_DRIVE, COEF_MAX);
		write_register(REG_MODE, {21'h1FFFFF, MODE_BAND});
		settings_used++;
		pending_samples.push_back(SAMPLE_MAX);
		pending_samples.push_back(SAMPLE_MIN);
		drain_filter();

		for (m = MODE_HIGH; m <= MODE_SPARE_B; m++) begin
			write_register(REG_MODE, COEF_BITS'(m));
			settings_used++;
			pending_samples.push_back(SAMPLE_MAX);
			pending_samples.push_back(SAMPLE_MIN);
			drain_filter();
		end

		write_register(REG_MODE, COEF_BITS'(MODE_BYPASS));
		settings_used++;
		pending_samples.push_back('0);
		drain_filter();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			configure_random();
			// first phase runs back to back, the rest idle at random
			src_idle  = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
			sink_idle = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
			// hold the output off long enough to back up the input
			if (p == 2) begin
				src_idle = 1'b0;
				long_stall_request = LONG_STALL;
			end
			for (n = 0; n < PHASE_SAMPLES; n++)
				pending_samples.push_back(random_sample());
			drain_filter();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Checked %0d of %0d samples across %0d register settings (%0d writes).",
			results_checked, samples_accepted, settings_used, reg_writes);
		$display("Per mode: bypass %0d, low %0d, band %0d, high %0d, notch %0d, peak %0d, spare %0d",
			mode_hits[MODE_BYPASS], mode_hits[MODE_LOW], mode_hits[MODE_BAND], mode_hits[MODE_HIGH],
			mode_hits[MODE_NOTCH], mode_hits[MODE_PEAK],
			mode_hits[MODE_SPARE_A] + mode_hits[MODE_SPARE_B]);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
